// ===== hdl/rdq_pkg.sv =====
// Package: types, codes and sizes shared by the reversible deque modules.
package rdq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int CMDQ_DEPTH   = 2;
  localparam int RESQ_DEPTH   = 4;
  localparam int LEN_W        = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REVERSE    = 3'd4,
    CMD_WALK_FWD   = 3'd5,
    CMD_WALK_BACK  = 3'd6
  } cmd_e;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_REVERSE,
    OP_WALK,
    OP_NOP
  } op_kind_e;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } exec_state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [LEN_W-1:0]   length;
    logic               last;
    logic [1:0]         status;
  } result_t;

  // front_end: push/pop at the logical front, or walk forward
  typedef struct packed {
    op_kind_e           kind;
    logic               front_end;
    logic signed [31:0] value;
  } op_t;

endpackage

// ===== hdl/rdq_fifo.sv =====
// Small synchronous queue of beats with occupancy count.
module rdq_fifo
  import rdq_pkg::*;
#(
  parameter type T     = logic,
  parameter int  DEPTH = CMDQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  T                           din,
  output logic                       full,
  input  logic                       pop,
  output T                           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  T             mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rdq_front.sv =====
// Front end: takes command beats, decodes them and queues them for execution.
module rdq_front
  import rdq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output op_t   op,
  output logic  op_valid,
  input  logic  op_take
);

  localparam int QCW = $clog2(CMDQ_DEPTH+1);

  op_t            dec;
  logic           q_empty;
  logic [QCW-1:0] q_count;

  always_comb begin
    dec.value     = item.value;
    dec.front_end = 1'b0;
    dec.kind      = OP_NOP;
    case (cmd_e'(item.cmd))
      CMD_PUSH_FRONT: begin
        dec.kind      = OP_PUSH;
        dec.front_end = 1'b1;
      end
      CMD_PUSH_BACK:  dec.kind = OP_PUSH;
      CMD_POP_FRONT: begin
        dec.kind      = OP_POP;
        dec.front_end = 1'b1;
      end
      CMD_POP_BACK:   dec.kind = OP_POP;
      CMD_REVERSE:    dec.kind = OP_REVERSE;
      CMD_WALK_FWD: begin
        dec.kind      = OP_WALK;
        dec.front_end = 1'b1;
      end
      CMD_WALK_BACK:  dec.kind = OP_WALK;
      default:        dec.kind = OP_NOP;
    endcase
  end

  rdq_fifo #(
    .T     (op_t),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (dec),
    .full  (full),
    .pop   (op_take),
    .dout  (op),
    .empty (q_empty),
    .count (q_count)
  );

  assign op_valid = !q_empty && (q_count != '0);

endmodule

// ===== hdl/rdq_back.sv =====
// Back end: ring storage, deque state, walk sequencer and result queue.
module rdq_back
  import rdq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic    clk,
  input  logic    rst,
  input  op_t     op,
  input  logic    op_valid,
  output logic    op_take,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY+1);
  localparam int RCW = $clog2(RESQ_DEPTH+1);

  logic signed [31:0] slots [CAPACITY];
  logic signed [31:0] mem_rd;

  exec_state_e   state, state_next;
  logic [PW-1:0] front_slot, front_slot_next;
  logic [CW-1:0] held_count, held_count_next;
  logic          reversed, reversed_next;

  logic [PW-1:0] ptr;
  logic [CW-1:0] remaining;
  logic          ascending;
  logic          rd_vld;
  logic          rd_last;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic          mem_re;
  logic          walk_start;
  logic          emit;
  logic [1:0]    emit_status;
  logic          issue_ok;
  logic          low_end;
  logic [PW-1:0] start_ptr;

  logic           res_push;
  result_t        res_in;
  logic           res_full;
  logic [RCW-1:0] res_count;

  function automatic logic [PW-1:0] inc_slot(input logic [PW-1:0] a);
    return (a == PW'(CAPACITY-1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [PW-1:0] dec_slot(input logic [PW-1:0] a);
    return (a == '0) ? PW'(CAPACITY-1) : a - 1'b1;
  endfunction

  // a + b mod CAPACITY, both below CAPACITY
  function automatic logic [PW-1:0] add_slot(input logic [PW-1:0] a, input logic [CW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + (PW+1)'(b);
    if (s >= (PW+1)'(CAPACITY)) begin
      s = s - (PW+1)'(CAPACITY);
    end
    return s[PW-1:0];
  endfunction

  assign low_end   = op.front_end != reversed;
  assign start_ptr = low_end ? front_slot : add_slot(front_slot, held_count - 1'b1);
  assign issue_ok  = rd_vld ? (res_count < RCW'(RESQ_DEPTH-1)) : !res_full;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (walk_start) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (issue_ok && remaining == CW'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op_take         = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = front_slot;
    mem_re          = 1'b0;
    walk_start      = 1'b0;
    emit            = 1'b0;
    emit_status     = STAT_OK;
    front_slot_next = front_slot;
    held_count_next = held_count;
    reversed_next   = reversed;
    case (state)
      S_IDLE: begin
        if (op_valid && !rd_vld && !res_full) begin
          op_take = 1'b1;
          case (op.kind)
            OP_PUSH: begin
              emit = 1'b1;
              if (held_count == CW'(CAPACITY)) begin
                emit_status = STAT_FULL;
              end else begin
                mem_we          = 1'b1;
                held_count_next = held_count + 1'b1;
                if (low_end) begin
                  front_slot_next = dec_slot(front_slot);
                  mem_waddr       = dec_slot(front_slot);
                end else begin
                  mem_waddr = add_slot(front_slot, held_count);
                end
              end
            end
            OP_POP: begin
              emit = 1'b1;
              if (held_count == '0) begin
                emit_status = STAT_EMPTY;
              end else begin
                held_count_next = held_count - 1'b1;
                if (low_end) begin
                  front_slot_next = inc_slot(front_slot);
                end
              end
            end
            OP_REVERSE: begin
              emit          = 1'b1;
              reversed_next = !reversed;
            end
            OP_WALK: begin
              if (held_count == '0) begin
                emit = 1'b1;
              end else begin
                walk_start = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_WALK: mem_re = issue_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[mem_waddr] <= op.value;
    end
    if (mem_re) begin
      mem_rd <= slots[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front_slot <= '0;
      held_count <= '0;
      reversed   <= 1'b0;
      rd_vld     <= 1'b0;
      ptr        <= '0;
      remaining  <= '0;
      ascending  <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      state      <= state_next;
      front_slot <= front_slot_next;
      held_count <= held_count_next;
      reversed   <= reversed_next;
      rd_vld     <= mem_re;
      if (walk_start) begin
        ptr       <= start_ptr;
        remaining <= held_count;
        ascending <= low_end;
      end else if (mem_re) begin
        ptr       <= ascending ? inc_slot(ptr) : dec_slot(ptr);
        remaining <= remaining - 1'b1;
        rd_last   <= (remaining == CW'(1));
      end
    end
  end

  always_comb begin
    res_push = rd_vld || emit;
    if (rd_vld) begin
      res_in.element = mem_rd;
      res_in.length  = LEN_W'(held_count);
      res_in.last    = rd_last;
      res_in.status  = STAT_OK;
    end else begin
      res_in.element = '0;
      res_in.length  = LEN_W'(held_count_next);
      res_in.last    = 1'b1;
      res_in.status  = emit_status;
    end
  end

  rdq_fifo #(
    .T     (result_t),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty),
    .count (res_count)
  );

endmodule

// ===== hdl/reversible_deque.sv =====
// Top level of the reversible deque: command front end and executing back end.
// Bounded double-ended queue of signed 32-bit words held in a ring of CAPACITY
// slots. Commands enter through a two-beat command queue and results leave
// through a four-beat result queue, so either side may stall on its own. The
// executor handles push, pop, reverse and unused codes with one result beat
// apiece. A walk of N held elements holds the executor while it starts, then
// reads one element per step through the single read port of the slot memory,
// pausing while the result queue lacks room, and lets the last read land in the
// result queue; a walk of an empty store gives one beat with length zero. Pushing
// to a full store reports status full, popping an empty one reports status empty;
// nothing changes in either case.
module reversible_deque
  import rdq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  op_t  op;
  logic op_valid;
  logic op_take;

  rdq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .op       (op),
    .op_valid (op_valid),
    .op_take  (op_take)
  );

  rdq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .op_valid (op_valid),
    .op_take  (op_take),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
